>>> hw/rtl/tcw_pkg.sv
// shared constants, types and codes of the text console cell writer
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int MAX_COLUMNS = 160;
  localparam int MAX_ROWS    = 60;
  localparam int TAB_WIDTH   = 8;
  localparam int CELL_COUNT  = MAX_ROWS * MAX_COLUMNS;

  localparam int COL_W  = 8;
  localparam int ROW_W  = 6;
  localparam int CLR_W  = 4;
  localparam int CHAR_W = 8;
  localparam int CELL_W = CHAR_W + 2 * CLR_W;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int TAB_B  = $clog2(TAB_WIDTH);

  localparam int NUM_REGS = 5;
  localparam int PADDR_W  = $clog2(4 * NUM_REGS);
  localparam int PDATA_W  = 32;

  // register indexes
  localparam logic [2:0] REG_COLUMNS = 3'd0;
  localparam logic [2:0] REG_ROWS    = 3'd1;
  localparam logic [2:0] REG_FG      = 3'd2;
  localparam logic [2:0] REG_BG      = 3'd3;
  localparam logic [2:0] REG_ENABLE  = 3'd4;

  localparam logic [COL_W-1:0] RST_COLUMNS = 8'd80;
  localparam logic [ROW_W-1:0] RST_ROWS    = 6'd25;
  localparam logic [CLR_W-1:0] DEF_FG      = 4'd7;
  localparam logic [CLR_W-1:0] DEF_BG      = 4'd0;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic CMD_PUT   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_BS_WR,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_CLR,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic              cell_written;
    logic [COL_W-1:0]  written_column;
    logic [ROW_W-1:0]  written_row;
    logic [CHAR_W-1:0] written_char;
    logic [CLR_W-1:0]  written_fg;
    logic [CLR_W-1:0]  written_bg;
    logic              scrolled;
    logic              cleared;
  } result_t;

  function automatic logic [CELL_W-1:0] make_cell(logic [CHAR_W-1:0] code,
                                                  logic [CLR_W-1:0] fg,
                                                  logic [CLR_W-1:0] bg);
    return {bg, fg, code};
  endfunction

endpackage

>>> hw/rtl/tcw_in_if.sv
// input channel of the text console cell writer
`timescale 1ns / 1ps
interface tcw_in_if
  import tcw_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, command, char_code, input ready);
  modport sink (input valid, command, char_code, output ready);
endinterface

>>> hw/rtl/tcw_out_if.sv
// result channel of the text console cell writer
`timescale 1ns / 1ps
interface tcw_out_if
  import tcw_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;
  logic              cell_written;
  logic [COL_W-1:0]  written_column;
  logic [ROW_W-1:0]  written_row;
  logic [CHAR_W-1:0] written_char;
  logic [CLR_W-1:0]  written_fg;
  logic [CLR_W-1:0]  written_bg;
  logic              scrolled;
  logic              cleared;

  modport source (output valid, cursor_column, cursor_row, cell_written, written_column,
                  written_row, written_char, written_fg, written_bg, scrolled, cleared,
                  input ready);
  modport sink (input valid, cursor_column, cursor_row, cell_written, written_column,
                written_row, written_char, written_fg, written_bg, scrolled, cleared,
                output ready);
endinterface

>>> hw/rtl/text_console_cell_writer_core.sv
// text console cell writer: cell store, cursor, scroll and clear sequencer
`timescale 1ns / 1ps
// A transaction on in_i puts one character byte or clears the screen; each one gives exactly
// one transaction on out_o with the cursor and the cell it wrote. The cells live in a
// single-port 9600 x 16 synchronous RAM (code in bits 7..0, foreground 11..8, background
// 15..12), and all timing follows from that one port. A printable byte, a control code that
// does not scroll or an ignored item goes through the execute state to the output state,
// which loads its result, and then the next item is accepted; a backspace first reads the
// cell left of the cursor and then writes a blank into it. A line feed or wrap at the bottom
// row scrolls the in-use area: each cell of rows 1..rows-1 moves up one row, then the bottom
// row is refilled with blanks; a clear writes every in-use cell. After reset a clearing pass
// writes all 9600 cells, one per cycle, before the first item is accepted; register writes
// are taken during that pass. The next item is accepted while a result still waits on out_o.
module text_console_cell_writer_core
  import tcw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  tcw_in_if.sink             in_i,
  tcw_out_if.source          out_o
);

  // configuration registers
  logic [COL_W-1:0] cols_cfg_q;
  logic [ROW_W-1:0] rows_cfg_q;
  logic [CLR_W-1:0] fg_q;
  logic [CLR_W-1:0] bg_q;
  logic             en_q;
  logic             cfg_wr;
  logic [2:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= RST_COLUMNS;
      rows_cfg_q <= RST_ROWS;
      fg_q       <= DEF_FG;
      bg_q       <= DEF_BG;
      en_q       <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COLUMNS: cols_cfg_q <= pwdata[COL_W-1:0];
        REG_ROWS:    rows_cfg_q <= pwdata[ROW_W-1:0];
        REG_FG:      fg_q       <= pwdata[CLR_W-1:0];
        REG_BG:      bg_q       <= pwdata[CLR_W-1:0];
        REG_ENABLE:  en_q       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COLUMNS: prdata = PDATA_W'(cols_cfg_q);
      REG_ROWS:    prdata = PDATA_W'(rows_cfg_q);
      REG_FG:      prdata = PDATA_W'(fg_q);
      REG_BG:      prdata = PDATA_W'(bg_q);
      REG_ENABLE:  prdata = PDATA_W'(en_q);
      default:     prdata = '0;
    endcase
  end

  // screen size in use, saturated to 1..max
  logic [COL_W-1:0] live_cols;
  logic [ROW_W-1:0] live_rows;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  always_comb begin
    if (cols_cfg_q == '0) begin
      live_cols = COL_W'(1);
    end else if ({1'b0, cols_cfg_q} > (COL_W+1)'(MAX_COLUMNS)) begin
      live_cols = COL_W'(MAX_COLUMNS);
    end else begin
      live_cols = cols_cfg_q;
    end
    if (rows_cfg_q == '0) begin
      live_rows = ROW_W'(1);
    end else if ({1'b0, rows_cfg_q} > (ROW_W+1)'(MAX_ROWS)) begin
      live_rows = ROW_W'(MAX_ROWS);
    end else begin
      live_rows = rows_cfg_q;
    end
  end

  assign col_last = live_cols - COL_W'(1);
  assign row_last = live_rows - ROW_W'(1);

  // cell store
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we;
  logic              mem_re;
  logic [ROW_W-1:0]  mem_row;
  logic [COL_W-1:0]  mem_col;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_addr;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] init_q, init_d;

  assign mem_addr = (state_q == ST_INIT) ? init_q :
                    ADDR_W'(ADDR_W'(mem_row) * ADDR_W'(MAX_COLUMNS)) + ADDR_W'(mem_col);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // sequencer
  logic              cmd_q, cmd_d;
  logic [CHAR_W-1:0] code_q, code_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  wk_col_q, wk_col_d;
  logic [ROW_W-1:0]  wk_row_q, wk_row_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [COL_W-1:0]  col_s;
  logic [ROW_W-1:0]  row_s;
  logic [COL_W:0]    tab_col;
  logic [COL_W:0]    inc_col;
  logic [CELL_W-1:0] bs_cell;

  assign col_s   = (cur_col_q > col_last) ? col_last : cur_col_q;
  assign row_s   = (cur_row_q > row_last) ? row_last : cur_row_q;
  assign tab_col = {1'b0, col_s} + (COL_W+1)'(TAB_WIDTH)
                 - (COL_W+1)'(col_s[TAB_B-1:0]);
  assign inc_col = {1'b0, col_s} + (COL_W+1)'(1);
  assign bs_cell = {rdata_q[CELL_W-1:CHAR_W], CH_SPACE};

  always_comb begin
    logic new_line;
    new_line    = 1'b0;
    state_d     = state_q;
    init_d      = init_q;
    cmd_d       = cmd_q;
    code_d      = code_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    wk_col_d    = wk_col_q;
    wk_row_d    = wk_row_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_row     = wk_row_q;
    mem_col     = wk_col_q;
    mem_wdata   = make_cell(CH_SPACE, DEF_FG, DEF_BG);
    in_i.ready  = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        init_d = init_q + ADDR_W'(1);
        if (init_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          cmd_d   = in_i.command;
          code_d  = in_i.char_code;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = '0;
        state_d = ST_OUT;
        if (cmd_q == CMD_CLEAR) begin
          cur_col_d     = '0;
          cur_row_d     = '0;
          wk_col_d      = '0;
          wk_row_d      = '0;
          res_d.cleared = 1'b1;
          state_d       = ST_CLR;
        end else if (en_q) begin
          cur_col_d = col_s;
          cur_row_d = row_s;
          if (code_q == CH_CR) begin
            cur_col_d = '0;
          end else if (code_q == CH_LF) begin
            new_line = 1'b1;
          end else if (code_q == CH_TAB) begin
            cur_col_d = tab_col[COL_W-1:0];
            new_line  = (tab_col >= {1'b0, live_cols});
          end else if (code_q == CH_BS) begin
            if (col_s != '0) begin
              cur_col_d = col_s - COL_W'(1);
              mem_row   = row_s;
              mem_col   = col_s - COL_W'(1);
              mem_re    = 1'b1;
              state_d   = ST_BS_WR;
            end
          end else if (code_q >= CH_SPACE) begin
            mem_row              = row_s;
            mem_col              = col_s;
            mem_we               = 1'b1;
            mem_wdata            = make_cell(code_q, fg_q, bg_q);
            res_d.cell_written   = 1'b1;
            res_d.written_column = col_s;
            res_d.written_row    = row_s;
            res_d.written_char   = code_q;
            res_d.written_fg     = fg_q;
            res_d.written_bg     = bg_q;
            cur_col_d            = inc_col[COL_W-1:0];
            new_line             = (inc_col >= {1'b0, live_cols});
          end
          if (new_line) begin
            cur_col_d = '0;
            if (row_s == row_last) begin
              // bottom row: scroll the in-use area up one row
              cur_row_d      = row_last;
              res_d.scrolled = 1'b1;
              wk_col_d       = '0;
              if (row_last == '0) begin
                wk_row_d = row_last;
                state_d  = ST_FILL;
              end else begin
                wk_row_d = '0;
                state_d  = ST_SCR_RD;
              end
            end else begin
              cur_row_d = row_s + ROW_W'(1);
            end
          end
        end
      end
      ST_BS_WR: begin
        mem_row              = cur_row_q;
        mem_col              = cur_col_q;
        mem_we               = 1'b1;
        mem_wdata            = bs_cell;
        res_d.cell_written   = 1'b1;
        res_d.written_column = cur_col_q;
        res_d.written_row    = cur_row_q;
        res_d.written_char   = bs_cell[CHAR_W-1:0];
        res_d.written_fg     = bs_cell[CHAR_W+CLR_W-1:CHAR_W];
        res_d.written_bg     = bs_cell[CELL_W-1:CHAR_W+CLR_W];
        state_d              = ST_OUT;
      end
      ST_SCR_RD: begin
        mem_row = wk_row_q + ROW_W'(1);
        mem_re  = 1'b1;
        state_d = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        state_d   = ST_SCR_RD;
        if (wk_col_q == col_last) begin
          wk_col_d = '0;
          if (wk_row_q + ROW_W'(1) == row_last) begin
            wk_row_d = row_last;
            state_d  = ST_FILL;
          end else begin
            wk_row_d = wk_row_q + ROW_W'(1);
          end
        end else begin
          wk_col_d = wk_col_q + COL_W'(1);
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = make_cell(CH_SPACE, fg_q, bg_q);
        if (wk_col_q == col_last) begin
          state_d = ST_OUT;
        end else begin
          wk_col_d = wk_col_q + COL_W'(1);
        end
      end
      ST_CLR: begin
        mem_we = 1'b1;
        if (wk_col_q == col_last) begin
          wk_col_d = '0;
          if (wk_row_q == row_last) begin
            state_d = ST_OUT;
          end else begin
            wk_row_d = wk_row_q + ROW_W'(1);
          end
        end else begin
          wk_col_d = wk_col_q + COL_W'(1);
        end
      end
      ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_o.ready) begin
          out_d               = res_q;
          out_d.cursor_column = cur_col_q;
          out_d.cursor_row    = cur_row_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      wk_col_q    <= '0;
      wk_row_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      wk_col_q    <= wk_col_d;
      wk_row_q    <= wk_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    code_q <= code_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.cursor_column  = out_q.cursor_column;
  assign out_o.cursor_row     = out_q.cursor_row;
  assign out_o.cell_written   = out_q.cell_written;
  assign out_o.written_column = out_q.written_column;
  assign out_o.written_row    = out_q.written_row;
  assign out_o.written_char   = out_q.written_char;
  assign out_o.written_fg     = out_q.written_fg;
  assign out_o.written_bg     = out_q.written_bg;
  assign out_o.scrolled       = out_q.scrolled;
  assign out_o.cleared        = out_q.cleared;

  // an accepted transaction is executed in the very next cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_EXEC)
    else $error("accepted transaction not executed");

  // a result is only loaded while the output side is free or being drained
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && out_valid_q && !out_o.ready |=> state_q == ST_OUT)
    else $error("pending result overwritten");

  // a cleared screen always reports the home position
  a_clear_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.cleared |-> out_q.cursor_column == '0 && out_q.cursor_row == '0)
    else $error("clear did not home the cursor");

  // walk counters stay inside the in-use area during scroll and clear
  a_walk_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCR_WR || state_q == ST_FILL || state_q == ST_CLR)
      |-> wk_col_q <= col_last && wk_row_q <= row_last)
    else $error("walk left the in-use area");

endmodule
